>>> design/dual_motor_limit_climb_sequencer_defines.svh
// Assertion macros used by the climb sequencer RTL
`ifndef DUAL_MOTOR_LIMIT_CLIMB_SEQUENCER_DEFINES_SVH
`define DUAL_MOTOR_LIMIT_CLIMB_SEQUENCER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define DMLC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("climb sequencer check failed (same cycle)");

// Next-cycle implication, disabled during reset
`define DMLC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("climb sequencer check failed (next cycle)");

`endif

>>> design/dmlc_pkg.sv
package dmlc_pkg;

   // Sequencer modes, numbered as reported in mode_code
   typedef enum logic [3:0] {
      MODE_BOTH_TILL   = 4'd0,
      MODE_L_TILL      = 4'd1,
      MODE_R_TILL      = 4'd2,
      MODE_UP_IDLE     = 4'd3,
      MODE_DWN_IDLE    = 4'd4,
      MODE_BOTH_UP     = 4'd5,
      MODE_LEFT_UP     = 4'd6,
      MODE_RIGHT_UP    = 4'd7,
      MODE_L_UP_IDLE   = 4'd8,
      MODE_R_UP_IDLE   = 4'd9,
      MODE_BOTH_DWN    = 4'd10,
      MODE_LEFT_DWN    = 4'd11,
      MODE_RIGHT_DWN   = 4'd12,
      MODE_L_DWN_IDLE  = 4'd13,
      MODE_R_DWN_IDLE  = 4'd14,
      MODE_ERROR       = 4'd15
   } mode_type;

   // Motor commands, two's complement
   localparam logic signed [1:0] DRIVE_UP   = 2'sb01;
   localparam logic signed [1:0] DRIVE_STOP = 2'sb00;
   localparam logic signed [1:0] DRIVE_DOWN = 2'sb11;

   localparam int unsigned REQ_WIDTH = 8;
   localparam int unsigned RSP_WIDTH = 8;

   // Request word, lowest bit last
   typedef struct packed {
      logic pad;
      logic recover_down;
      logic recover_up;
      logic run_button;
      logic left_bottom_limit;
      logic right_bottom_limit;
      logic left_top_limit;
      logic right_top_limit;
   } req_word_type;

   // Result word, lowest field last
   typedef struct packed {
      logic [3:0]        mode_code;
      logic signed [1:0] right_drive;
      logic signed [1:0] left_drive;
   } rsp_word_type;

   function automatic logic signed [1:0] left_drive_of(input mode_type mode);
      logic signed [1:0] drive;
      unique case (mode)
         MODE_BOTH_TILL, MODE_L_TILL, MODE_BOTH_UP, MODE_LEFT_UP: drive = DRIVE_UP;
         MODE_BOTH_DWN, MODE_LEFT_DWN:                           drive = DRIVE_DOWN;
         default:                                                drive = DRIVE_STOP;
      endcase
      return drive;
   endfunction

   function automatic logic signed [1:0] right_drive_of(input mode_type mode);
      logic signed [1:0] drive;
      unique case (mode)
         MODE_BOTH_TILL, MODE_R_TILL, MODE_BOTH_UP, MODE_RIGHT_UP: drive = DRIVE_UP;
         MODE_BOTH_DWN, MODE_RIGHT_DWN:                           drive = DRIVE_DOWN;
         default:                                                 drive = DRIVE_STOP;
      endcase
      return drive;
   endfunction

endpackage

>>> design/dmlc_next.sv
module dmlc_next (
   input  dmlc_pkg::mode_type     mode,
   input  dmlc_pkg::req_word_type req,
   output dmlc_pkg::mode_type     next_mode,
   output dmlc_pkg::rsp_word_type rsp
);
   import dmlc_pkg::*;

   logic conflict;
   logic lt, rt, lb, rb, run;

   assign lt  = req.left_top_limit;
   assign rt  = req.right_top_limit;
   assign lb  = req.left_bottom_limit;
   assign rb  = req.right_bottom_limit;
   assign run = req.run_button;

   // Both limits of one side at once means a broken switch
   assign conflict = (lt && lb) || (rt && rb);

   // Advance the mode for one tick
   always_comb begin
      next_mode = mode;
      if (conflict) begin
         next_mode = MODE_ERROR;
      end else begin
         unique case (mode)
            MODE_BOTH_TILL: begin
               priority if (lt && rt) next_mode = MODE_DWN_IDLE;
               else if (rt)           next_mode = MODE_L_TILL;
               else if (lt)           next_mode = MODE_R_TILL;
               else                   next_mode = mode;
            end
            MODE_L_TILL:     if (lt)  next_mode = MODE_DWN_IDLE;
            MODE_R_TILL:     if (rt)  next_mode = MODE_DWN_IDLE;
            MODE_UP_IDLE:    if (run) next_mode = MODE_BOTH_UP;
            MODE_BOTH_UP: begin
               priority if (!run)     next_mode = MODE_UP_IDLE;
               else if (lt && rt)     next_mode = MODE_BOTH_DWN;
               else if (rt)           next_mode = MODE_LEFT_UP;
               else if (lt)           next_mode = MODE_RIGHT_UP;
               else                   next_mode = mode;
            end
            MODE_LEFT_UP: begin
               priority if (!run)     next_mode = MODE_L_UP_IDLE;
               else if (lt)           next_mode = MODE_BOTH_DWN;
               else                   next_mode = mode;
            end
            MODE_L_UP_IDLE:  if (run) next_mode = MODE_LEFT_UP;
            MODE_RIGHT_UP: begin
               priority if (!run)     next_mode = MODE_R_UP_IDLE;
               else if (rt)           next_mode = MODE_BOTH_DWN;
               else                   next_mode = mode;
            end
            MODE_R_UP_IDLE:  if (run) next_mode = MODE_RIGHT_UP;
            MODE_DWN_IDLE:   if (run) next_mode = MODE_BOTH_DWN;
            MODE_BOTH_DWN: begin
               priority if (!run)     next_mode = MODE_DWN_IDLE;
               else if (lb && rb)     next_mode = MODE_BOTH_UP;
               else if (rb)           next_mode = MODE_LEFT_DWN;
               else if (lb)           next_mode = MODE_RIGHT_DWN;
               else                   next_mode = mode;
            end
            MODE_LEFT_DWN: begin
               priority if (!run)     next_mode = MODE_L_DWN_IDLE;
               else if (lb)           next_mode = MODE_BOTH_UP;
               else                   next_mode = mode;
            end
            MODE_RIGHT_DWN: begin
               priority if (!run)     next_mode = MODE_R_DWN_IDLE;
               else if (rb)           next_mode = MODE_BOTH_UP;
               else                   next_mode = mode;
            end
            MODE_L_DWN_IDLE: if (run) next_mode = MODE_LEFT_DWN;
            MODE_R_DWN_IDLE: if (run) next_mode = MODE_RIGHT_DWN;
            MODE_ERROR: begin
               // recover_up wins when both are pressed
               priority if (req.recover_up) next_mode = MODE_UP_IDLE;
               else if (req.recover_down)   next_mode = MODE_DWN_IDLE;
               else                         next_mode = MODE_ERROR;
            end
            default:                  next_mode = MODE_ERROR;
         endcase
      end
   end

   // Decode motor commands from the new mode
   always_comb begin
      rsp.left_drive  = left_drive_of(next_mode);
      rsp.right_drive = right_drive_of(next_mode);
      rsp.mode_code   = 4'(next_mode);
   end

endmodule

>>> design/dual_motor_limit_climb_sequencer.sv
// An accepted request word's result is registered in the output register, or in
// the skid register while the output stalls. Throughput: one word per cycle unless
// rsp_tready stalls; the mode update is a single pass through the next-state logic,
// and a two-entry result buffer keeps req_tready high until the skid entry fills.
// Reset: synchronous, active high; mode returns to error (code 15), buffer empties.
`include "dual_motor_limit_climb_sequencer_defines.svh"

module dual_motor_limit_climb_sequencer (
   input  logic       clock,
   input  logic       reset,
   // req_tdata: right_top_limit, left_top_limit, right_bottom_limit,
   //            left_bottom_limit, run_button, recover_up, recover_down, zero pad
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [dmlc_pkg::REQ_WIDTH-1:0] req_tdata,
   // rsp_tdata: left_drive[1:0], right_drive[3:2], mode_code[7:4]
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [dmlc_pkg::RSP_WIDTH-1:0] rsp_tdata
);
   import dmlc_pkg::*;

   mode_type     mode_ff, mode_in;
   rsp_word_type step_rsp;
   req_word_type req_word;

   logic         out_valid_ff, out_valid_in;
   rsp_word_type out_data_ff, out_data_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_word_type skid_data_ff, skid_data_in;

   logic         accept;
   logic         out_moves;
   logic         conflict_seen;

   assign req_word   = req_word_type'(req_tdata);
   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign out_moves  = !out_valid_ff || rsp_tready;

   dmlc_next u_next (
      .mode      (mode_ff),
      .req       (req_word),
      .next_mode (mode_in),
      .rsp       (step_rsp)
   );

   // Hold the mode; advance on every accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_ERROR;
      end else if (accept) begin
         mode_ff <= mode_in;
      end
   end

   // Steer result words through the output and skid registers
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_moves) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in  = accept;
            out_data_in   = step_rsp;
         end
      end else if (accept) begin
         skid_valid_in = 1'b1;
         skid_data_in  = step_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Payload registers need no reset
   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_WIDTH'(out_data_ff);

   assign conflict_seen = (req_word.left_top_limit && req_word.left_bottom_limit) ||
                          (req_word.right_top_limit && req_word.right_bottom_limit);

   // Skid entry is only ever filled behind a full output register
   `DMLC_ASSERT_NOW(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff)
   // A conflicting limit pair always lands in error
   `DMLC_ASSERT_NEXT(a_conflict_error, clock, reset, accept && conflict_seen,
                     mode_ff == MODE_ERROR)
   // A word accepted while the output stalls is parked in the skid entry
   `DMLC_ASSERT_NEXT(a_stall_parks, clock, reset, accept && !out_moves,
                     skid_valid_ff)
   // The reported mode code matches the mode register after a direct load
   `DMLC_ASSERT_NEXT(a_code_tracks_mode, clock, reset, accept && out_moves,
                     out_data_ff.mode_code == 4'(mode_ff))

endmodule

>>> test/tb.sv
module tb;
   import dmlc_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned MAX_WAIT     = 14;
   localparam int unsigned DRAIN_CYCLES = 4;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [REQ_WIDTH-1:0] req_tdata;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [RSP_WIDTH-1:0] rsp_tdata;

   // predicted mode after the last accepted word, and the drive words still owed
   mode_type     model_mode = MODE_ERROR;
   rsp_word_type drive_forecast[$];
   int unsigned  mismatches  = 0;
   int unsigned  cycle_count = 0;
   bit           steady      = 1'b0;   // no gaps and no stalls while set
   bit           running     = 1'b0;

   dual_motor_limit_climb_sequencer uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Next mode for one tick of switches and buttons
   function automatic mode_type next_mode(input mode_type cur, input req_word_type w);
      mode_type nxt;
      nxt = cur;
      if ((w.left_top_limit && w.left_bottom_limit) ||
          (w.right_top_limit && w.right_bottom_limit)) begin
         return MODE_ERROR;
      end
      case (cur)
         MODE_BOTH_TILL: begin
            if (w.left_top_limit && w.right_top_limit) nxt = MODE_DWN_IDLE;
            else if (w.right_top_limit)                nxt = MODE_L_TILL;
            else if (w.left_top_limit)                 nxt = MODE_R_TILL;
         end
         MODE_L_TILL:     if (w.left_top_limit)  nxt = MODE_DWN_IDLE;
         MODE_R_TILL:     if (w.right_top_limit) nxt = MODE_DWN_IDLE;
         MODE_UP_IDLE:    if (w.run_button) nxt = MODE_BOTH_UP;
         MODE_DWN_IDLE:   if (w.run_button) nxt = MODE_BOTH_DWN;
         MODE_L_UP_IDLE:  if (w.run_button) nxt = MODE_LEFT_UP;
         MODE_R_UP_IDLE:  if (w.run_button) nxt = MODE_RIGHT_UP;
         MODE_L_DWN_IDLE: if (w.run_button) nxt = MODE_LEFT_DWN;
         MODE_R_DWN_IDLE: if (w.run_button) nxt = MODE_RIGHT_DWN;
         MODE_BOTH_UP: begin
            if (!w.run_button)                              nxt = MODE_UP_IDLE;
            else if (w.left_top_limit && w.right_top_limit) nxt = MODE_BOTH_DWN;
            else if (w.right_top_limit)                     nxt = MODE_LEFT_UP;
            else if (w.left_top_limit)                      nxt = MODE_RIGHT_UP;
         end
         MODE_LEFT_UP: begin
            if (!w.run_button)          nxt = MODE_L_UP_IDLE;
            else if (w.left_top_limit)  nxt = MODE_BOTH_DWN;
         end
         MODE_RIGHT_UP: begin
            if (!w.run_button)          nxt = MODE_R_UP_IDLE;
            else if (w.right_top_limit) nxt = MODE_BOTH_DWN;
         end
         MODE_BOTH_DWN: begin
            if (!w.run_button)                                    nxt = MODE_DWN_IDLE;
            else if (w.left_bottom_limit && w.right_bottom_limit) nxt = MODE_BOTH_UP;
            else if (w.right_bottom_limit)                        nxt = MODE_LEFT_DWN;
            else if (w.left_bottom_limit)                         nxt = MODE_RIGHT_DWN;
         end
         MODE_LEFT_DWN: begin
            if (!w.run_button)             nxt = MODE_L_DWN_IDLE;
            else if (w.left_bottom_limit)  nxt = MODE_BOTH_UP;
         end
         MODE_RIGHT_DWN: begin
            if (!w.run_button)             nxt = MODE_R_DWN_IDLE;
            else if (w.right_bottom_limit) nxt = MODE_BOTH_UP;
         end
         default: begin
            // recovery: up takes priority over down
            if (w.recover_up)        nxt = MODE_UP_IDLE;
            else if (w.recover_down) nxt = MODE_DWN_IDLE;
            else                     nxt = MODE_ERROR;
         end
      endcase
      return nxt;
   endfunction

   // Motor commands and mode code reported for a mode
   function automatic rsp_word_type outputs_of(input mode_type m);
      rsp_word_type o;
      o.mode_code   = m;
      o.left_drive  = DRIVE_STOP;
      o.right_drive = DRIVE_STOP;
      case (m)
         MODE_BOTH_TILL, MODE_BOTH_UP: begin
            o.left_drive  = DRIVE_UP;
            o.right_drive = DRIVE_UP;
         end
         MODE_L_TILL, MODE_LEFT_UP:  o.left_drive  = DRIVE_UP;
         MODE_R_TILL, MODE_RIGHT_UP: o.right_drive = DRIVE_UP;
         MODE_BOTH_DWN: begin
            o.left_drive  = DRIVE_DOWN;
            o.right_drive = DRIVE_DOWN;
         end
         MODE_LEFT_DWN:  o.left_drive  = DRIVE_DOWN;
         MODE_RIGHT_DWN: o.right_drive = DRIVE_DOWN;
         default: ;
      endcase
      return o;
   endfunction

   function automatic req_word_type switches(input bit rt, input bit lt, input bit rb,
                                             input bit lb, input bit run,
                                             input bit rec_up, input bit rec_dn);
      req_word_type w;
      w                    = '0;
      w.right_top_limit    = rt;
      w.left_top_limit     = lt;
      w.right_bottom_limit = rb;
      w.left_bottom_limit  = lb;
      w.run_button         = run;
      w.recover_up         = rec_up;
      w.recover_down       = rec_dn;
      return w;
   endfunction

   // Mostly sane switch patterns: run held, limits now and then, rare conflicts
   function automatic req_word_type plausible_word();
      req_word_type w;
      w                    = '0;
      w.run_button         = ($urandom_range(0, 7) != 0);
      w.right_top_limit    = ($urandom_range(0, 3) == 0);
      w.left_top_limit     = ($urandom_range(0, 3) == 0);
      w.right_bottom_limit = ($urandom_range(0, 3) == 0);
      w.left_bottom_limit  = ($urandom_range(0, 3) == 0);
      if (w.left_top_limit && w.left_bottom_limit && $urandom_range(0, 7) != 0)
         w.left_bottom_limit = 1'b0;
      if (w.right_top_limit && w.right_bottom_limit && $urandom_range(0, 7) != 0)
         w.right_bottom_limit = 1'b0;
      if (model_mode == MODE_ERROR) begin
         w.recover_up   = ($urandom_range(0, 1) != 0);
         w.recover_down = ($urandom_range(0, 1) != 0);
      end else begin
         w.recover_up   = ($urandom_range(0, 7) == 0);
         w.recover_down = ($urandom_range(0, 7) == 0);
      end
      return w;
   endfunction

   // Offer one word after a random gap, hold it until taken, then predict
   task automatic send_word(input req_word_type w);
      int unsigned gap;
      gap = steady ? 0 : $urandom_range(0, MAX_WAIT);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      do @(posedge clock); while (!req_tready);
      model_mode = next_mode(model_mode, w);
      drive_forecast.push_back(outputs_of(model_mode));
   endtask

   task automatic check_field(input string field, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
         mismatches++;
      end
   endtask

   // Walk every reachable mode and the main transitions, extremes of the switch word included
   task automatic test_directed();
      send_word(switches(0, 0, 0, 0, 0, 0, 0));   // stay in error
      send_word(switches(0, 0, 0, 0, 0, 1, 1));   // both recoveries: up wins
      send_word(switches(0, 0, 0, 0, 1, 0, 0));
      send_word(switches(0, 0, 0, 0, 0, 0, 0));   // release pauses
      send_word(switches(0, 0, 0, 0, 1, 0, 0));
      send_word(switches(1, 0, 0, 0, 1, 0, 0));   // right at top, left goes on
      send_word(switches(0, 0, 0, 0, 0, 0, 0));
      send_word(switches(0, 0, 0, 0, 1, 0, 0));
      send_word(switches(0, 1, 0, 0, 1, 0, 0));   // left reaches top: reverse
      send_word(switches(0, 0, 1, 0, 1, 0, 0));
      send_word(switches(0, 0, 0, 0, 0, 0, 0));
      send_word(switches(0, 0, 0, 0, 1, 0, 0));
      send_word(switches(0, 0, 0, 1, 1, 0, 0));   // left reaches bottom: reverse
      send_word(switches(0, 1, 0, 0, 1, 0, 0));
      send_word(switches(0, 0, 0, 0, 0, 0, 0));
      send_word(switches(0, 0, 0, 0, 1, 0, 0));
      send_word(switches(1, 0, 0, 0, 1, 0, 0));
      send_word(switches(0, 0, 0, 1, 1, 0, 0));
      send_word(switches(0, 0, 0, 0, 0, 0, 0));
      send_word(switches(0, 0, 0, 0, 1, 0, 0));
      send_word(switches(0, 0, 1, 0, 1, 0, 0));
      send_word(switches(1, 1, 0, 0, 1, 0, 0));   // both at top together
      send_word(switches(0, 0, 1, 1, 1, 0, 0));   // both at bottom together
      send_word(switches(1, 1, 1, 1, 1, 1, 1));   // conflicting limits
      send_word(switches(0, 0, 0, 0, 0, 0, 1));   // recover downwards
      send_word(switches(0, 0, 0, 0, 1, 0, 0));
      send_word(switches(0, 1, 0, 1, 1, 0, 0));   // conflict on the left only
   endtask

   // Back-to-back climbing with no idling on either side
   task automatic test_steady_climb();
      steady = 1'b1;
      repeat (300) send_word(plausible_word());
      steady = 1'b0;
   endtask

   // Climbing with random gaps and stalls, broken by short steady runs
   task automatic test_mixed_traffic();
      for (int i = 0; i < 1300; i++) begin
         steady = ((i % 128) >= 100);
         send_word(plausible_word());
      end
      steady = 1'b0;
   endtask

   // Arbitrary switch words
   task automatic test_switch_noise();
      repeat (300) send_word(req_word_type'({1'b0, 7'($urandom)}));
   endtask

   // Pace the result side: random stall before each word
   initial begin : rsp_pacing
      int unsigned stall;
      rsp_tready <= 1'b0;
      wait (running);
      forever begin
         stall = steady ? 0 : $urandom_range(0, MAX_WAIT);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Compare each accepted result word with the oldest prediction
   always @(posedge clock) begin : result_check
      rsp_word_type got;
      rsp_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (drive_forecast.size() == 0) begin
            $display("%0t: unexpected result word, expected none actual %h", $time, got);
            mismatches++;
         end else begin
            want = drive_forecast.pop_front();
            check_field("left_drive", int'(want.left_drive), int'(got.left_drive));
            check_field("right_drive", int'(want.right_drive), int'(got.right_drive));
            check_field("mode_code", int'(want.mode_code), int'(got.mode_code));
         end
      end
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      repeat (6) @(posedge clock);
      reset   <= 1'b0;
      running = 1'b1;

      test_directed();
      test_steady_climb();
      test_mixed_traffic();
      test_switch_noise();

      // drain outstanding words, then watch for strays
      req_tvalid <= 1'b0;
      while (drive_forecast.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+design
design/dmlc_pkg.sv
design/dmlc_next.sv
design/dual_motor_limit_climb_sequencer.sv
test/tb.sv
